/* sv/pidp_pkg.sv */
package pidp_pkg;

  typedef enum logic [2:0] {
    CFG_TARGET     = 3'd0,
    CFG_GAIN_P     = 3'd1,
    CFG_GAIN_I     = 3'd2,
    CFG_GAIN_D     = 3'd3,
    CFG_SETTLE_ERR = 3'd4,
    CFG_SETTLE_RT  = 3'd5,
    CFG_INT_LIMIT  = 3'd6,
    CFG_MODE       = 3'd7
  } cfg_idx_t;

  localparam logic [15:0] GAIN_P_RST     = 16'd614;
  localparam logic [15:0] GAIN_I_RST     = 16'd70;
  localparam logic [15:0] GAIN_D_RST     = 16'd5120;
  localparam logic [15:0] SETTLE_ERR_RST = 16'd383;
  localparam logic [15:0] SETTLE_RT_RST  = 16'd4;
  localparam logic [6:0]  INT_LIMIT_RST  = 7'd46;

  localparam int unsigned FRAC_SHIFT = 19;

  localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
  localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};

  typedef struct packed {
    logic [23:0] target_position;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] settle_error;
    logic [15:0] settle_rate;
    logic [6:0]  integral_limit;
    logic [1:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic [24:0] err;
    logic [25:0] deriv;
    logic [39:0] integ;
  } stage1_t;

  typedef struct packed {
    logic [41:0] prod_p;
    logic [42:0] prod_d;
    logic [56:0] prod_i;
    logic [24:0] err;
    logic        done;
  } stage2_t;

endpackage

/* sv/pidp_update.sv */
module pidp_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              start_req,
  input  logic [23:0]       measured,
  input  pidp_pkg::cfg_t    cfg,
  output pidp_pkg::stage1_t s1
);

  logic signed [39:0] integ;
  logic signed [24:0] prev_err;

  logic signed [24:0] err;
  logic signed [25:0] deriv;
  logic signed [39:0] base;
  logic signed [40:0] acc;
  logic signed [39:0] integ_sat;
  logic signed [39:0] integ_sr;
  logic signed [56:0] clamp_prod;
  logic signed [56:0] clamp_lim;
  logic signed [39:0] integ_next;
  logic               sign_flip;

  always_comb begin
    err   = $signed({cfg.target_position[23], cfg.target_position})
          - $signed({measured[23], measured});
    deriv = $signed({err[24], err}) - $signed({prev_err[24], prev_err});
    base  = start_req ? '0 : integ;
    acc   = $signed({base[39], base}) + $signed({{16{err[24]}}, err});
    if (acc[40] != acc[39]) begin
      integ_sat = acc[40] ? pidp_pkg::INTEG_MIN : pidp_pkg::INTEG_MAX;
    end else begin
      integ_sat = acc[39:0];
    end
    sign_flip = ((err < 0) && (prev_err > 0)) || ((err > 0) && (prev_err < 0));
    integ_sr  = (cfg.mode[0] && sign_flip) ? '0 : integ_sat;
    clamp_prod = integ_sr * $signed({1'b0, cfg.gain_i});
    clamp_lim  = $signed({31'b0, cfg.integral_limit, 19'b0});
    if (clamp_prod > clamp_lim) begin
      integ_next = $signed({26'b0, cfg.integral_limit, 7'b0});
    end else begin
      integ_next = integ_sr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      prev_err <= '0;
    end else if (en) begin
      integ    <= integ_next;
      prev_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.err   <= err;
      s1.deriv <= deriv;
      s1.integ <= integ_next;
    end
  end

endmodule

/* sv/pidp_mult.sv */
module pidp_mult (
  input  logic              clk,
  input  logic              en,
  input  pidp_pkg::stage1_t s1,
  input  pidp_pkg::cfg_t    cfg,
  output pidp_pkg::stage2_t s2
);

  logic signed [41:0] prod_p;
  logic signed [42:0] prod_d;
  logic signed [56:0] prod_i;
  logic [24:0]        err_mag;
  logic [25:0]        deriv_mag;
  logic               done;

  always_comb begin
    prod_p    = $signed(s1.err) * $signed({1'b0, cfg.gain_p});
    prod_d    = $signed(s1.deriv) * $signed({1'b0, cfg.gain_d});
    prod_i    = $signed(s1.integ) * $signed({1'b0, cfg.gain_i});
    err_mag   = s1.err[24] ? (25'd0 - s1.err) : s1.err;
    deriv_mag = s1.deriv[25] ? (26'd0 - s1.deriv) : s1.deriv;
    done = ((err_mag <= {9'b0, cfg.settle_error}) && (deriv_mag <= {10'b0, cfg.settle_rate}))
        || (cfg.mode[1] && s1.err[24]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.prod_p <= prod_p;
      s2.prod_d <= prod_d;
      s2.prod_i <= prod_i;
      s2.err    <= s1.err;
      s2.done   <= done;
    end
  end

endmodule

/* sv/pidp_out.sv */
module pidp_out (
  input  logic              clk,
  input  logic              en,
  input  logic              turn,
  input  pidp_pkg::stage2_t s2,
  output logic [7:0]        drive,
  output logic              done_res,
  output logic [24:0]       error_now
);

  logic signed [57:0] sum;
  logic signed [57:0] bias;
  logic signed [57:0] sum_adj;
  logic signed [38:0] quot;
  logic signed [7:0]  drv_sat;
  logic signed [7:0]  drv_next;

  always_comb begin
    sum = $signed({{16{s2.prod_p[41]}}, s2.prod_p})
        + $signed({{15{s2.prod_d[42]}}, s2.prod_d})
        + $signed({s2.prod_i[56], s2.prod_i});
    bias    = $signed({39'b0, {pidp_pkg::FRAC_SHIFT{sum[57]}}});
    sum_adj = sum + bias;
    quot    = sum_adj[57:pidp_pkg::FRAC_SHIFT];
    if (quot > 39'sd127) begin
      drv_sat = 8'sd127;
    end else if (quot < -39'sd127) begin
      drv_sat = -8'sd127;
    end else begin
      drv_sat = quot[7:0];
    end
    drv_next = turn ? (8'sd0 - drv_sat) : drv_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drive     <= drv_next;
      done_res  <= s2.done;
      error_now <= s2.err;
    end
  end

endmodule

/* sv/pid_position_controller_unit.sv */
// Each item goes through input, update, multiply and output registers; a stall holds it.
// Throughput: one item per cycle unless stalled; the integral loop closes within one stage.
// Each stage holds its item while downstream is full and fills bubbles otherwise.
// Reset (synchronous, active high) sets registers to their defaults, clears the
// integral and previous error, and empties the pipeline.
module pid_position_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // measured[23:0]
  input  logic [0:0]  s_axis_tuser,   // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // drive[7:0], error_now[32:8], zero pad[39:33]
  output logic [0:0]  m_axis_tuser,   // done_res
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_data
);

  pidp_pkg::cfg_t    cfg;
  pidp_pkg::stage1_t s1;
  pidp_pkg::stage2_t s2;

  logic        v0, v1, v2, v3;
  logic        rdy0, rdy1, rdy2, rdy3;
  logic        in_start;
  logic [23:0] in_meas;
  logic [7:0]  drive;
  logic        done_res;
  logic [24:0] error_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_position <= '0;
      cfg.gain_p          <= pidp_pkg::GAIN_P_RST;
      cfg.gain_i          <= pidp_pkg::GAIN_I_RST;
      cfg.gain_d          <= pidp_pkg::GAIN_D_RST;
      cfg.settle_error    <= pidp_pkg::SETTLE_ERR_RST;
      cfg.settle_rate     <= pidp_pkg::SETTLE_RT_RST;
      cfg.integral_limit  <= pidp_pkg::INT_LIMIT_RST;
      cfg.mode            <= '0;
    end else if (cfg_we) begin
      unique case (pidp_pkg::cfg_idx_t'(cfg_addr))
        pidp_pkg::CFG_TARGET:     cfg.target_position <= cfg_data;
        pidp_pkg::CFG_GAIN_P:     cfg.gain_p          <= cfg_data[15:0];
        pidp_pkg::CFG_GAIN_I:     cfg.gain_i          <= cfg_data[15:0];
        pidp_pkg::CFG_GAIN_D:     cfg.gain_d          <= cfg_data[15:0];
        pidp_pkg::CFG_SETTLE_ERR: cfg.settle_error    <= cfg_data[15:0];
        pidp_pkg::CFG_SETTLE_RT:  cfg.settle_rate     <= cfg_data[15:0];
        pidp_pkg::CFG_INT_LIMIT:  cfg.integral_limit  <= cfg_data[6:0];
        pidp_pkg::CFG_MODE:       cfg.mode            <= cfg_data[1:0];
        default:                  cfg.mode            <= cfg.mode;
      endcase
    end
  end

  assign rdy3 = !v3 || m_axis_tready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy0) begin
        v0 <= s_axis_tvalid;
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && s_axis_tvalid) begin
      in_start <= s_axis_tuser[0];
      in_meas  <= s_axis_tdata;
    end
  end

  pidp_update u_update (
    .clk       (clk),
    .rst       (rst),
    .en        (rdy1 && v0),
    .start_req (in_start),
    .measured  (in_meas),
    .cfg       (cfg),
    .s1        (s1)
  );

  pidp_mult u_mult (
    .clk (clk),
    .en  (rdy2 && v1),
    .s1  (s1),
    .cfg (cfg),
    .s2  (s2)
  );

  pidp_out u_out (
    .clk       (clk),
    .en        (rdy3 && v2),
    .turn      (cfg.mode[0]),
    .s2        (s2),
    .drive     (drive),
    .done_res  (done_res),
    .error_now (error_now)
  );

  assign m_axis_tvalid   = v3;
  assign m_axis_tdata    = {7'b0, error_now, drive};
  assign m_axis_tuser[0] = done_res;

endmodule

/* sv/pidp_checker.sv */
module pidp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result item changed");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[7:0] != 8'h80)
    else $error("drive outside saturation range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("result padding not zero");

endmodule

bind pid_position_controller_unit pidp_checker u_pidp_checker (.*);
